// File: rtl/core/twinkle_star_pixel_generator_defines.svh
// Assertion macros for the twinkle star pixel generator.
// Both expect clk and rst_n in the scope of use.
`ifndef TWINKLE_STAR_PIXEL_GENERATOR_DEFINES_SVH
`define TWINKLE_STAR_PIXEL_GENERATOR_DEFINES_SVH

// same-cycle implication
`define TSPG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/tspg_pkg.sv
`timescale 1ns / 1ps
package tspg_pkg;

  // grid and star count
  localparam int COLUMNS     = 16;
  localparam int ROWS        = 16;
  localparam int STARS       = 16;
  localparam int MAX_RESULTS = 16;
  localparam int STAR_COUNT  = (STARS < MAX_RESULTS) ? STARS : MAX_RESULTS;
  localparam int STAR_CNT_W  = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;

  // field widths
  localparam int PHASE_W  = 32;
  localparam int SPEED_W  = 10;
  localparam int COORD_W  = 4;
  localparam int COLOUR_W = 8;

  // wave position is taken mod 512
  localparam int BASE_W = 9;

  // phase divisor 400/sp + 1 lies in 2..41
  localparam int DIVR_W = 6;

  // config register map
  localparam int           CFG_ADDR_W     = 3;
  localparam logic         REG_SPEED      = 1'b0;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 10'd100;

  // front/back queue
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [BASE_W-1:0]  base;
  } tspg_job_t;

  typedef struct packed {
    logic [COORD_W-1:0]  pixel_x;
    logic [COORD_W-1:0]  pixel_y;
    logic [COLOUR_W-1:0] red;
    logic [COLOUR_W-1:0] green;
    logic [COLOUR_W-1:0] blue;
    logic                last_star;
  } tspg_pixel_t;

endpackage

// File: rtl/core/tspg_if.sv
`timescale 1ns / 1ps
interface tspg_in_if import tspg_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [PHASE_W-1:0] frame_phase;

  modport source (output valid, output frame_phase, input ready);
  modport sink (input valid, input frame_phase, output ready);
endinterface

interface tspg_out_if import tspg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [COLOUR_W-1:0] red;
  logic [COLOUR_W-1:0] green;
  logic [COLOUR_W-1:0] blue;
  logic                last_star;

  modport source (output valid, output pixel_x, output pixel_y, output red,
                  output green, output blue, output last_star, input ready);
  modport sink (input valid, input pixel_x, input pixel_y, input red,
                input green, input blue, input last_star, output ready);
endinterface

// File: rtl/core/tspg_front.sv
`timescale 1ns / 1ps
module tspg_front import tspg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [SPEED_W-1:0] speed_percent,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [PHASE_W-1:0] in_phase,
  output logic               job_valid,
  input  logic               job_ready,
  output tspg_job_t          job
);

  localparam int SPEED_MIN  = 10;
  localparam int SPEED_MAX  = 300;
  localparam int WAVE_SPAN  = 400;
  localparam int SP_W       = 9;
  localparam int QUO_W      = 6;
  localparam int ACC_W      = SP_W + QUO_W - 1;
  localparam int DIV_STEP   = 4;
  localparam int DIV_ITER   = PHASE_W / DIV_STEP;
  localparam int DIV_CNT_W  = $clog2(DIV_ITER);

  typedef enum logic [2:0] {
    FE_IDLE = 3'b001,
    FE_DIV  = 3'b010,
    FE_DONE = 3'b100
  } fe_state_t;

  // 400/clamp(sp) + 1, restoring division over six narrow steps
  function automatic logic [DIVR_W-1:0] speed_divisor(input logic [SPEED_W-1:0] sp);
    logic [SP_W-1:0]  spc;
    logic [ACC_W-1:0] acc;
    logic [ACC_W-1:0] den;
    logic [QUO_W-1:0] quo;
    if (sp < SPEED_W'(SPEED_MIN)) begin
      spc = SP_W'(SPEED_MIN);
    end else if (sp > SPEED_W'(SPEED_MAX)) begin
      spc = SP_W'(SPEED_MAX);
    end else begin
      spc = sp[SP_W-1:0];
    end
    acc = ACC_W'(WAVE_SPAN);
    quo = '0;
    for (int k = QUO_W - 1; k >= 0; k--) begin
      den = ACC_W'(spc) << k;
      if (acc >= den) begin
        acc    = acc - den;
        quo[k] = 1'b1;
      end
    end
    return DIVR_W'(quo + QUO_W'(1));
  endfunction

  fe_state_t             state_r, state_nxt;
  logic                  hold_valid_r, hold_valid_nxt;
  logic [PHASE_W-1:0]    hold_phase_r;
  logic [PHASE_W-1:0]    phase_r;
  logic [PHASE_W-1:0]    quo_r, quo_w;
  logic [DIVR_W-1:0]     rem_r, rem_w;
  logic [DIVR_W-1:0]     divisor_r;
  logic [DIV_CNT_W-1:0]  cnt_r;
  logic                  load;

  assign in_ready  = !hold_valid_r;
  assign job_valid = (state_r == FE_DIV) ? 1'b0 : (state_r == FE_DONE);
  assign job.phase = phase_r;
  assign job.base  = quo_r[BASE_W-1:0];
  assign load      = (state_r == FE_IDLE) && hold_valid_r;

  // four quotient bits per cycle
  always_comb begin
    logic [DIVR_W:0] rem_ext;
    rem_w = rem_r;
    quo_w = quo_r;
    for (int j = 0; j < DIV_STEP; j++) begin
      rem_ext = {rem_w, quo_w[PHASE_W-1]};
      quo_w   = {quo_w[PHASE_W-2:0], 1'b0};
      if (rem_ext >= {1'b0, divisor_r}) begin
        rem_ext  = rem_ext - {1'b0, divisor_r};
        quo_w[0] = 1'b1;
      end
      rem_w = rem_ext[DIVR_W-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    hold_valid_nxt = hold_valid_r;
    if (in_valid && in_ready) begin
      hold_valid_nxt = 1'b1;
    end else if (load) begin
      hold_valid_nxt = 1'b0;
    end
    unique case (state_r)
      FE_IDLE: begin
        if (hold_valid_r) begin
          state_nxt = FE_DIV;
        end
      end
      FE_DIV: begin
        if (cnt_r == DIV_CNT_W'(DIV_ITER - 1)) begin
          state_nxt = FE_DONE;
        end
      end
      FE_DONE: begin
        if (job_ready) begin
          state_nxt = FE_IDLE;
        end
      end
      default: state_nxt = FE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= FE_IDLE;
      hold_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    divisor_r <= speed_divisor(speed_percent);
    if (in_valid && in_ready) begin
      hold_phase_r <= in_phase;
    end
    if (load) begin
      phase_r <= hold_phase_r;
      quo_r   <= hold_phase_r;
      rem_r   <= '0;
      cnt_r   <= '0;
    end else if (state_r == FE_DIV) begin
      quo_r <= quo_w;
      rem_r <= rem_w;
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

endmodule

// File: rtl/core/tspg_queue.sv
`timescale 1ns / 1ps
module tspg_queue import tspg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push_valid,
  output logic      push_ready,
  input  tspg_job_t push_job,
  output logic      pop_valid,
  input  logic      pop_ready,
  output tspg_job_t pop_job
);

  tspg_job_t          slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r;
  logic [QPTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0]  count_r;
  logic               push;
  logic               pop;

  assign push_ready = (count_r < QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_job    = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// File: rtl/core/tspg_back.sv
`timescale 1ns / 1ps
module tspg_back import tspg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_ready,
  input  tspg_job_t   job,
  output logic        out_valid,
  input  logic        out_ready,
  output tspg_pixel_t out_pixel
);

  localparam logic [PHASE_W-1:0]  SEED_MASK  = 32'hA53C9E21;
  localparam logic [COLOUR_W-1:0] SATURATION = 8'd180;
  localparam logic [COLOUR_W-1:0] FULL       = 8'd255;
  localparam int                  HUE_SECTOR = 43;

  typedef enum logic [2:0] {
    HUE_RY = 3'd0,
    HUE_YG = 3'd1,
    HUE_GC = 3'd2,
    HUE_CB = 3'd3,
    HUE_BM = 3'd4,
    HUE_MR = 3'd5
  } hue_region_t;

  function automatic logic [PHASE_W-1:0] xorshift(input logic [PHASE_W-1:0] s);
    logic [PHASE_W-1:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  // floor(x/255), exact for x below 65280
  function automatic logic [COLOUR_W-1:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return sum[15:8];
  endfunction

  function automatic logic [COLOUR_W-1:0] triangle(input logic [BASE_W-1:0] p);
    return p[BASE_W-1] ? ~p[COLOUR_W-1:0] : p[COLOUR_W-1:0];
  endfunction

  logic en;

  // star generator
  logic                  gen_active_r;
  logic [PHASE_W-1:0]    seed_r;
  logic [BASE_W-1:0]     base_r;
  logic [STAR_CNT_W-1:0] idx_r;
  logic                  gen_last;
  logic [PHASE_W-1:0]    seed_step;

  // S1: raw random word
  logic                  s1_valid_r;
  logic [PHASE_W-1:0]    s1_rnd_r;
  logic [BASE_W-1:0]     s1_base_r;
  logic                  s1_last_r;

  // S2: position, value, hue region
  logic                  s2_valid_r;
  logic [COORD_W-1:0]    s2_x_r, s2_y_r;
  logic [COLOUR_W-1:0]   s2_v_r;
  hue_region_t           s2_region_r;
  logic [COLOUR_W-1:0]   s2_rem_r;
  logic                  s2_last_r;

  // S3: saturation products
  logic                  s3_valid_r;
  logic [COORD_W-1:0]    s3_x_r, s3_y_r;
  logic [COLOUR_W-1:0]   s3_v_r;
  hue_region_t           s3_region_r;
  logic [15:0]           s3_sq_r, s3_st_r, s3_sp_r;
  logic                  s3_last_r;

  // S4: value products
  logic                  s4_valid_r;
  logic [COORD_W-1:0]    s4_x_r, s4_y_r;
  logic [COLOUR_W-1:0]   s4_v_r, s4_pl_r;
  hue_region_t           s4_region_r;
  logic [15:0]           s4_mq_r, s4_mt_r;
  logic                  s4_last_r;

  logic                  out_valid_r;
  tspg_pixel_t           out_pixel_r;

  // S1 comb
  logic [COLOUR_W-1:0]   s1_hue;
  logic [COLOUR_W-1:0]   s1_hbase;
  hue_region_t           s1_region;
  logic [BASE_W-1:0]     s1_pos;
  // S3 comb
  logic [COLOUR_W-1:0]   s3_aq, s3_at;
  // S4 comb
  logic [COLOUR_W-1:0]   s4_q, s4_t;
  tspg_pixel_t           pix_nxt;

  assign en        = !out_valid_r || out_ready;
  assign gen_last  = (idx_r == STAR_CNT_W'(STAR_COUNT - 1));
  assign seed_step = xorshift(seed_r);
  assign job_ready = en && (!gen_active_r || gen_last);
  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  always_comb begin
    s1_hue = s1_rnd_r[PHASE_W-1 -: COLOUR_W];
    s1_pos = s1_base_r + s1_rnd_r[16 +: BASE_W];
    if (s1_hue >= COLOUR_W'(5 * HUE_SECTOR)) begin
      s1_region = HUE_MR;
      s1_hbase  = COLOUR_W'(5 * HUE_SECTOR);
    end else if (s1_hue >= COLOUR_W'(4 * HUE_SECTOR)) begin
      s1_region = HUE_BM;
      s1_hbase  = COLOUR_W'(4 * HUE_SECTOR);
    end else if (s1_hue >= COLOUR_W'(3 * HUE_SECTOR)) begin
      s1_region = HUE_CB;
      s1_hbase  = COLOUR_W'(3 * HUE_SECTOR);
    end else if (s1_hue >= COLOUR_W'(2 * HUE_SECTOR)) begin
      s1_region = HUE_GC;
      s1_hbase  = COLOUR_W'(2 * HUE_SECTOR);
    end else if (s1_hue >= COLOUR_W'(HUE_SECTOR)) begin
      s1_region = HUE_YG;
      s1_hbase  = COLOUR_W'(HUE_SECTOR);
    end else begin
      s1_region = HUE_RY;
      s1_hbase  = '0;
    end
  end

  assign s3_aq = div255(s3_sq_r);
  assign s3_at = div255(s3_st_r);
  assign s4_q  = div255(s4_mq_r);
  assign s4_t  = div255(s4_mt_r);

  always_comb begin
    pix_nxt.pixel_x   = s4_x_r;
    pix_nxt.pixel_y   = s4_y_r;
    pix_nxt.last_star = s4_last_r;
    case (s4_region_r)
      HUE_YG: begin
        pix_nxt.red = s4_q;    pix_nxt.green = s4_v_r;  pix_nxt.blue = s4_pl_r;
      end
      HUE_GC: begin
        pix_nxt.red = s4_pl_r; pix_nxt.green = s4_v_r;  pix_nxt.blue = s4_t;
      end
      HUE_CB: begin
        pix_nxt.red = s4_pl_r; pix_nxt.green = s4_q;    pix_nxt.blue = s4_v_r;
      end
      HUE_BM: begin
        pix_nxt.red = s4_t;    pix_nxt.green = s4_pl_r; pix_nxt.blue = s4_v_r;
      end
      HUE_MR: begin
        pix_nxt.red = s4_v_r;  pix_nxt.green = s4_pl_r; pix_nxt.blue = s4_q;
      end
      default: begin
        pix_nxt.red = s4_v_r;  pix_nxt.green = s4_t;    pix_nxt.blue = s4_pl_r;
      end
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_active_r <= 1'b0;
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      s3_valid_r   <= 1'b0;
      s4_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else if (en) begin
      if (job_valid && job_ready) begin
        gen_active_r <= 1'b1;
      end else if (gen_active_r && gen_last) begin
        gen_active_r <= 1'b0;
      end
      s1_valid_r  <= gen_active_r;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // datapath; products are formed at full 16-bit width
  always_ff @(posedge clk) begin
    if (en) begin
      if (job_valid && job_ready) begin
        seed_r <= SEED_MASK ^ job.phase;
        base_r <= job.base;
        idx_r  <= '0;
      end else if (gen_active_r) begin
        seed_r <= seed_step;
        idx_r  <= idx_r + STAR_CNT_W'(1);
      end
      s1_rnd_r  <= seed_step;
      s1_base_r <= base_r;
      s1_last_r <= gen_last;

      s2_x_r      <= COORD_W'(s1_rnd_r % COLUMNS);
      s2_y_r      <= COORD_W'((s1_rnd_r / COLUMNS) % ROWS);
      s2_v_r      <= triangle(s1_pos);
      s2_region_r <= s1_region;
      s2_rem_r    <= COLOUR_W'(6 * (s1_hue - s1_hbase));
      s2_last_r   <= s1_last_r;

      s3_x_r      <= s2_x_r;
      s3_y_r      <= s2_y_r;
      s3_v_r      <= s2_v_r;
      s3_region_r <= s2_region_r;
      s3_sq_r     <= {8'd0, SATURATION} * {8'd0, s2_rem_r};
      s3_st_r     <= {8'd0, SATURATION} * {8'd0, FULL - s2_rem_r};
      s3_sp_r     <= {8'd0, s2_v_r} * {8'd0, FULL - SATURATION};
      s3_last_r   <= s2_last_r;

      s4_x_r      <= s3_x_r;
      s4_y_r      <= s3_y_r;
      s4_v_r      <= s3_v_r;
      s4_pl_r     <= div255(s3_sp_r);
      s4_region_r <= s3_region_r;
      s4_mq_r     <= {8'd0, s3_v_r} * {8'd0, FULL - s3_aq};
      s4_mt_r     <= {8'd0, s3_v_r} * {8'd0, FULL - s3_at};
      s4_last_r   <= s3_last_r;

      out_pixel_r <= pix_nxt;
    end
  end

endmodule

// File: rtl/core/twinkle_star_pixel_generator.sv
`timescale 1ns / 1ps
// Channel   Dir  Handshake             Word
// in_chan   in   valid/ready           frame_phase[31:0]
// out_chan  out  valid/ready           pixel_x, pixel_y, red, green, blue, last_star
// cfg (APB) in   psel/penable/pready   speed_percent at byte address 0
//
// Rate: STAR_COUNT (16) words a frame, one a cycle unless out_chan stalls, frames
//   back to back; the star generator, one xorshift step per word, sets this.
// Front: a load state, then the phase divider (4 quotient bits a cycle), then
//   the job waits in a 2-deep queue; the back runs it through S1-S4 to out_pixel_r.
// Reset: synchronous, active low; speed_percent returns to 100. No clearing pass.
// Stalls: a held word freezes only the star pipeline; the front fills the queue.
module twinkle_star_pixel_generator import tspg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tspg_in_if.sink               in_chan,
  tspg_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  // speed register; the front clamps it and derives its divisor in a register
  logic [SPEED_W-1:0] speed_r;
  logic               cfg_write;

  // front -> queue
  logic               fq_valid, fq_ready;
  tspg_job_t          fq_job;
  // queue -> back
  logic               qb_valid, qb_ready;
  tspg_job_t          qb_job;
  // back -> port
  tspg_pixel_t        pixel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  // paddr[2] picks the register; low bits are byte offset
  assign prdata    = (paddr[2] == REG_SPEED) ? {{(32 - SPEED_W){1'b0}}, speed_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= SPEED_RESET;
    end else if (cfg_write && (paddr[2] == REG_SPEED)) begin
      speed_r <= pwdata[SPEED_W-1:0];
    end
  end

  tspg_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .speed_percent (speed_r),
    .in_valid      (in_chan.valid),
    .in_ready      (in_chan.ready),
    .in_phase      (in_chan.frame_phase),
    .job_valid     (fq_valid),
    .job_ready     (fq_ready),
    .job           (fq_job)
  );

  // decouples the divider from the star pipeline
  tspg_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_job   (fq_job),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_job    (qb_job)
  );

  tspg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (qb_valid),
    .job_ready (qb_ready),
    .job       (qb_job),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_pixel (pixel)
  );

  assign out_chan.pixel_x   = pixel.pixel_x;
  assign out_chan.pixel_y   = pixel.pixel_y;
  assign out_chan.red       = pixel.red;
  assign out_chan.green     = pixel.green;
  assign out_chan.blue      = pixel.blue;
  assign out_chan.last_star = pixel.last_star;

endmodule

// File: rtl/core/tspg_checker.sv
`timescale 1ns / 1ps
`include "twinkle_star_pixel_generator_defines.svh"
module tspg_checker import tspg_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [COORD_W-1:0]  pixel_x,
  input logic [COORD_W-1:0]  pixel_y,
  input logic [COLOUR_W-1:0] red,
  input logic [COLOUR_W-1:0] green,
  input logic [COLOUR_W-1:0] blue,
  input logic                last_star
);

  logic [3:0]            open_r;
  logic [STAR_CNT_W-1:0] star_r;
  logic                  in_acc;
  logic                  out_acc;
  logic                  frame_end;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign frame_end = out_acc && last_star;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
      star_r <= '0;
    end else begin
      if (in_acc && !frame_end) begin
        open_r <= open_r + 4'd1;
      end else if (frame_end && !in_acc) begin
        open_r <= open_r - 4'd1;
      end
      if (frame_end) begin
        star_r <= '0;
      end else if (out_acc) begin
        star_r <= star_r + STAR_CNT_W'(1);
      end
    end
  end

  `TSPG_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable({pixel_x, pixel_y, red, green, blue, last_star}), "output word changed while stalled")
  `TSPG_ASSERT_IMPL(a_no_orphan, out_valid, open_r != 4'd0, "word shown with no frame outstanding")
  `TSPG_ASSERT_IMPL(a_last_pos, out_acc && last_star, star_r == STAR_CNT_W'(STAR_COUNT - 1), "frame closed at wrong star count")
  `TSPG_ASSERT_IMPL(a_frame_len, out_acc && !last_star, star_r != STAR_CNT_W'(STAR_COUNT - 1), "frame ran past its star count")

endmodule

bind twinkle_star_pixel_generator tspg_checker u_tspg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .pixel_x   (out_chan.pixel_x),
  .pixel_y   (out_chan.pixel_y),
  .red       (out_chan.red),
  .green     (out_chan.green),
  .blue      (out_chan.blue),
  .last_star (out_chan.last_star)
);
